// ===== rtl/core/text_integer_parser_top_assert.svh =====
// Assertion macros shared by the parser modules.
`ifndef TEXT_INTEGER_PARSER_TOP_ASSERT_SVH
`define TEXT_INTEGER_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define TIP_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define TIP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define TIP_ASSERT(lbl, expr)
`define TIP_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ===== rtl/core/tip_pkg.sv =====
`timescale 1ns / 1ps

package tip_pkg;

  localparam int MAX_LENGTH = 4096;
  localparam int VALUE_W = 32;
  localparam int POS_W = 12;
  localparam int BASE_W = 6;
  localparam int POS_CAP_INT = (MAX_LENGTH - 1 > 4095) ? 4095 : MAX_LENGTH - 1;
  localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_CAP_INT);

  // Queue depth must be a power of two.
  localparam int FIFO_DEPTH = 4;

  localparam logic [BASE_W-1:0] BASE_INFER = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;

  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_NINE = 8'd57;
  localparam logic [7:0] CH_UP_A = 8'd65;
  localparam logic [7:0] CH_UP_X = 8'd88;
  localparam logic [7:0] CH_UP_Z = 8'd90;
  localparam logic [7:0] CH_LO_A = 8'd97;
  localparam logic [7:0] CH_LO_X = 8'd120;
  localparam logic [7:0] CH_LO_Z = 8'd122;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS
  } tip_phase_t;

  typedef struct packed {
    logic       start_flag;
    logic [7:0] char_code;
  } tip_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] parsed_value;
    logic [POS_W-1:0]          end_offset;
    logic                      found_digits;
  } tip_out_t;

  typedef struct packed {
    logic              start;
    logic              blank;
    logic              plus;
    logic              minus;
    logic              is_x;
    logic              alnum;
    logic [BASE_W-1:0] digit;
    logic [BASE_W-1:0] base;
  } tip_entry_t;

endpackage

// ===== rtl/core/text_integer_parser_top.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Payload      Handshake
// in       input      tip_in_t     in_valid / in_ready
// out      output     tip_out_t    out_valid / out_ready
// cfg      input      number_base  cfg_valid / cfg_ready
//
// One character is accepted per cycle while the queue is not full, and the back end takes one
// per cycle unless a held result stalls it. An accepted item is first written into the queue,
// and the result it closes is registered at the edge that takes the item from the queue.
// The front end classifies each character into a four-entry queue; the back end runs the parse.
// Reset is synchronous and active low; the radix register resets to ten.
// A stalled result blocks the back end only, so the queue still absorbs up to four items.

module text_integer_parser_top import tip_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tip_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tip_out_t          out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [BASE_W-1:0] cfg_data
);

  logic [BASE_W-1:0] number_base_r;
  tip_entry_t        front_entry;
  logic              q_valid;
  logic              q_ready;
  tip_entry_t        q_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r <= BASE_DEC;
    end else if (cfg_valid && cfg_ready) begin
      number_base_r <= cfg_data;
    end
  end

  tip_front u_front (
    .in_data     (in_data),
    .number_base (number_base_r),
    .entry       (front_entry)
  );

  tip_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_entry (front_entry),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_entry  (q_entry)
  );

  tip_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_entry   (q_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/tip_front.sv =====
`timescale 1ns / 1ps

module tip_front import tip_pkg::*; (
  input  tip_in_t          in_data,
  input  logic [BASE_W-1:0] number_base,
  output tip_entry_t       entry
);

  logic [7:0] c;

  assign c = in_data.char_code;

  always_comb begin
    entry = '0;
    entry.start = in_data.start_flag;
    entry.base = number_base;
    entry.blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    entry.plus = (c == CH_PLUS);
    entry.minus = (c == CH_MINUS);
    entry.is_x = (c == CH_LO_X) || (c == CH_UP_X);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      entry.alnum = 1'b1;
      entry.digit = BASE_W'(c - CH_ZERO);
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      entry.alnum = 1'b1;
      entry.digit = BASE_W'(c - CH_LO_A + 8'd10);
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      entry.alnum = 1'b1;
      entry.digit = BASE_W'(c - CH_UP_A + 8'd10);
    end
  end

endmodule

// ===== rtl/core/tip_fifo.sv =====
`timescale 1ns / 1ps
`include "text_integer_parser_top_assert.svh"

module tip_fifo import tip_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  tip_entry_t push_entry,
  output logic       pop_valid,
  input  logic       pop_ready,
  output tip_entry_t pop_entry
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  tip_entry_t       mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             push;
  logic             pop;

  assign push_ready = (cnt_r != CNT_W'(FIFO_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign pop_entry = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  `TIP_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(FIFO_DEPTH))
  `TIP_ASSERT_NEXT(a_pop_dec, rst_n && pop && !push, cnt_r == $past(cnt_r) - 1'b1)

endmodule

// ===== rtl/core/tip_back.sv =====
`timescale 1ns / 1ps
`include "text_integer_parser_top_assert.svh"

module tip_back import tip_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  output logic       q_ready,
  input  tip_entry_t q_entry,
  output logic       out_valid,
  input  logic       out_ready,
  output tip_out_t   out_data
);

  tip_phase_t          phase_r;
  tip_phase_t          phase_nxt;
  logic [VALUE_W-1:0]  acc_r;
  logic [VALUE_W-1:0]  acc_nxt;
  logic                neg_r;
  logic                neg_nxt;
  logic [BASE_W-1:0]   base_r;
  logic [BASE_W-1:0]   base_nxt;
  logic [POS_W-1:0]    pos_r;
  logic [POS_W-1:0]    pos_nxt;
  logic                seen_r;
  logic                seen_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  tip_out_t            out_data_r;
  tip_out_t            out_data_nxt;
  logic                take;
  logic                emit;
  logic                no_digit_ok;

  assign q_ready = !out_valid_r || out_ready;
  assign take = q_valid && q_ready;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;
  assign no_digit_ok = out_data_r.found_digits ||
                       (out_data_r.end_offset == '0 && out_data_r.parsed_value == '0);

  always_comb begin
    logic stop;
    stop = 1'b0;
    emit = 1'b0;
    phase_nxt = phase_r;
    acc_nxt = acc_r;
    neg_nxt = neg_r;
    base_nxt = base_r;
    pos_nxt = pos_r;
    seen_nxt = seen_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (take && (q_entry.start || phase_r != PH_IDLE)) begin
      if (q_entry.start) begin
        phase_nxt = PH_SPACE;
        acc_nxt = '0;
        neg_nxt = 1'b0;
        base_nxt = q_entry.base;
        pos_nxt = '0;
        seen_nxt = 1'b0;
      end else if (pos_r < POS_CAP) begin
        pos_nxt = pos_r + 1'b1;
      end

      if (phase_nxt == PH_SPACE) begin
        if (q_entry.blank) begin
          stop = 1'b1;
        end else begin
          phase_nxt = PH_SIGNED;
          if (q_entry.plus || q_entry.minus) begin
            neg_nxt = q_entry.minus;
            stop = 1'b1;
          end
        end
      end

      if (!stop && phase_nxt == PH_SIGNED) begin
        if ((base_nxt == BASE_INFER || base_nxt == BASE_HEX) && q_entry.alnum &&
            q_entry.digit == '0) begin
          phase_nxt = PH_ZERO;
          stop = 1'b1;
        end else begin
          if (base_nxt == BASE_INFER) begin
            base_nxt = BASE_DEC;
          end
          phase_nxt = PH_DIGITS;
        end
      end

      if (!stop && phase_nxt == PH_ZERO) begin
        phase_nxt = PH_DIGITS;
        if (q_entry.is_x) begin
          base_nxt = BASE_HEX;
          stop = 1'b1;
        end else begin
          if (base_nxt == BASE_INFER) begin
            base_nxt = BASE_OCT;
          end
          acc_nxt = '0;
          seen_nxt = 1'b1;
        end
      end

      if (!stop && phase_nxt == PH_DIGITS) begin
        if (q_entry.alnum && q_entry.digit < base_nxt) begin
          acc_nxt = VALUE_W'(acc_nxt * VALUE_W'(base_nxt) + VALUE_W'(q_entry.digit));
          seen_nxt = 1'b1;
        end else begin
          emit = 1'b1;
          phase_nxt = PH_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt.parsed_value = neg_nxt ? -acc_nxt : acc_nxt;
          out_data_nxt.end_offset = seen_nxt ? pos_nxt : '0;
          out_data_nxt.found_digits = seen_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r <= '0;
      neg_r <= 1'b0;
      base_r <= '0;
      pos_r <= '0;
      seen_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      acc_r <= acc_nxt;
      neg_r <= neg_nxt;
      base_r <= base_nxt;
      pos_r <= pos_nxt;
      seen_r <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  `TIP_ASSERT(a_base_set, phase_r != PH_DIGITS || base_r != '0)
  `TIP_ASSERT_NEXT(a_emit_idle, rst_n && emit, phase_r == PH_IDLE && out_valid_r)
  `TIP_ASSERT(a_no_digits, !out_valid_r || no_digit_ok)

endmodule

// ===== tb/tip_parse_checker.sv =====
`timescale 1ns / 1ps

module tip_parse_checker import tip_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  tip_in_t           in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  tip_out_t          out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [BASE_W-1:0] cfg_data,
  output int                mismatch_count,
  output int                results_pending
);

  localparam logic [7:0] NUL_CODE = 8'd0;
  localparam logic [7:0] NOT_DIGIT = 8'd255;

  tip_phase_t          phase;
  logic [VALUE_W-1:0]  acc;
  logic                neg;
  logic [BASE_W-1:0]   base;
  logic [POS_W-1:0]    pos;
  logic                seen;
  logic [BASE_W-1:0]   radix;
  tip_out_t            expected_results[$];
  int                  fault_total = 0;

  function automatic logic [7:0] digit_of(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
    if (c >= CH_LO_A && c <= CH_LO_Z) return c - CH_LO_A + 8'd10;
    if (c >= CH_UP_A && c <= CH_UP_Z) return c - CH_UP_A + 8'd10;
    return NOT_DIGIT;
  endfunction

  // Advances the parser by one character and reports whether it closes a number.
  function bit parse_char(input tip_in_t item, output tip_out_t res);
    logic [7:0] c;
    logic [7:0] d;
    c = item.char_code;
    res = '0;
    if (item.start_flag) begin
      phase = PH_SPACE;
      acc = '0;
      neg = 1'b0;
      base = radix;
      pos = '0;
      seen = 1'b0;
    end else begin
      if (phase == PH_IDLE) return 1'b0;
      if (pos < POS_CAP) pos = pos + 1'b1;
    end
    if (phase == PH_SPACE) begin
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return 1'b0;
      phase = PH_SIGNED;
      if (c == CH_PLUS || c == CH_MINUS) begin
        neg = (c == CH_MINUS);
        return 1'b0;
      end
    end
    if (phase == PH_SIGNED) begin
      if ((base == BASE_INFER || base == BASE_HEX) && c == CH_ZERO) begin
        phase = PH_ZERO;
        return 1'b0;
      end
      if (base == BASE_INFER) base = BASE_DEC;
      phase = PH_DIGITS;
    end
    if (phase == PH_ZERO) begin
      phase = PH_DIGITS;
      if (c == CH_LO_X || c == CH_UP_X) begin
        base = BASE_HEX;
        return 1'b0;
      end
      if (base == BASE_INFER) base = BASE_OCT;
      acc = '0;
      seen = 1'b1;
    end
    if (phase == PH_DIGITS) begin
      d = digit_of(c);
      if (c != NUL_CODE && d != NOT_DIGIT && d < {2'b00, base}) begin
        acc = acc * base + d;
        seen = 1'b1;
        return 1'b0;
      end
      res.parsed_value = neg ? -acc : acc;
      res.end_offset = seen ? pos : '0;
      res.found_digits = seen;
      phase = PH_IDLE;
      return 1'b1;
    end
    phase = PH_IDLE;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    tip_out_t predicted;
    tip_out_t want;
    if (!rst_n) begin
      phase = PH_IDLE;
      acc = '0;
      neg = 1'b0;
      base = '0;
      pos = '0;
      seen = 1'b0;
      radix = BASE_DEC;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (fault_total < 10)
            $display("%0t: result with none expected: value %0d offset %0d found %0b",
                     $realtime, out_data.parsed_value, out_data.end_offset,
                     out_data.found_digits);
          fault_total++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.parsed_value !== want.parsed_value ||
              out_data.end_offset !== want.end_offset ||
              out_data.found_digits !== want.found_digits) begin
            if (fault_total < 10)
              $display("%0t: result differs: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                       $realtime, want.parsed_value, want.end_offset, want.found_digits,
                       out_data.parsed_value, out_data.end_offset, out_data.found_digits);
            fault_total++;
          end
        end
      end
      if (cfg_valid && cfg_ready) radix = cfg_data;
      if (in_valid && in_ready) begin
        if (parse_char(in_data, predicted)) expected_results.push_back(predicted);
      end
    end
    mismatch_count <= fault_total;
    results_pending <= expected_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import tip_pkg::*;

  localparam logic [7:0] NUL_CODE = 8'd0;

  typedef enum int {SIGN_NONE, SIGN_PLUS, SIGN_MINUS} sign_kind_t;
  typedef enum int {PFX_NONE, PFX_LOWER_X, PFX_UPPER_X, PFX_ZERO} prefix_kind_t;
  typedef enum int {END_NUL, END_RANDOM, END_OUTSIDE, END_NONE} stop_kind_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  tip_in_t           in_data = '0;
  logic              out_ready = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [BASE_W-1:0] cfg_data = BASE_DEC;
  logic              in_ready;
  logic              out_valid;
  logic              cfg_ready;
  tip_out_t          out_data;
  int                mismatch_count;
  int                results_pending;
  int                items_sent = 0;
  int                in_burst = 0;
  int                out_burst = 0;
  logic [BASE_W-1:0] phase_radix [9] = '{BASE_INFER, BASE_DEC, BASE_HEX, 6'd36, 6'd1,
                                         BASE_OCT, 6'd63, 6'd2, 6'd37};

  text_integer_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  tip_parse_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Waits are mostly random, with occasional runs of back-to-back transfers.
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  function automatic logic [7:0] digit_char(input int v, input bit upper);
    if (v < 10) return CH_ZERO + 8'(v);
    return (upper ? CH_UP_A : CH_LO_A) + 8'(v - 10);
  endfunction

  task automatic send_char(input logic st, input logic [7:0] c);
    int gap;
    gap = draw_wait(in_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{start_flag: st, char_code: c};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s, input logic st);
    for (int i = 0; i < s.len(); i++) send_char((i == 0) ? st : 1'b0, s[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_radix(input logic [BASE_W-1:0] b);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= b;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Builds and sends one number string for the given radix, now and then replaced by noise.
  task automatic random_string(input logic [BASE_W-1:0] radix);
    logic [7:0]   text[$];
    int           eff;
    sign_kind_t   sgn;
    prefix_kind_t pfx;
    stop_kind_t   stop;
    int           k;
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 6))
        send_char($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        k = $urandom_range(0, 5);
        text.push_back((k == 5) ? CH_SPACE : CH_TAB + 8'(k));
      end
    end
    sgn = sign_kind_t'($urandom_range(0, 2));
    if (sgn == SIGN_PLUS) text.push_back(CH_PLUS);
    if (sgn == SIGN_MINUS) text.push_back(CH_MINUS);
    eff = radix;
    if (radix == BASE_INFER || radix == BASE_HEX) begin
      pfx = prefix_kind_t'($urandom_range(0, 3));
      if (pfx != PFX_NONE) text.push_back(CH_ZERO);
      if (pfx == PFX_LOWER_X) text.push_back(CH_LO_X);
      if (pfx == PFX_UPPER_X) text.push_back(CH_UP_X);
      if (radix == BASE_INFER)
        eff = (pfx == PFX_NONE) ? 10 : (pfx == PFX_ZERO) ? 8 : 16;
    end
    if (eff > 36) eff = 36;
    repeat ($urandom_range(0, 12))
      text.push_back(digit_char($urandom_range(0, eff - 1), $urandom_range(0, 1)));
    stop = stop_kind_t'($urandom_range(0, 3));
    case (stop)
      END_NUL: text.push_back(NUL_CODE);
      END_RANDOM: text.push_back(8'($urandom_range(0, 255)));
      END_OUTSIDE: text.push_back((eff < 36) ? digit_char(eff, $urandom_range(0, 1)) : CH_PLUS);
      default: ;
    endcase
    foreach (text[i]) send_char(i == 0, text[i]);
    repeat ($urandom_range(0, 2)) send_char(1'b0, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait(out_burst);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int target;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_char(1'b1, CH_SPACE);
    for (int k = 9; k <= 13; k++) send_char(1'b0, 8'(k));
    send_text("-123", 1'b0);
    send_char(1'b0, NUL_CODE);
    send_text("+42x", 1'b1);
    send_text("77", 1'b0);
    send_text("abc", 1'b1);
    send_text("4294967297", 1'b1);
    send_char(1'b0, NUL_CODE);
    send_text("-2147483648", 1'b1);
    send_char(1'b0, NUL_CODE);
    send_text("98", 1'b1);
    send_text("5;", 1'b1);
    send_text("+", 1'b1);
    send_char(1'b0, NUL_CODE);
    // The radix is taken at the first character, so this string stays decimal.
    send_text("12", 1'b1);
    set_radix(BASE_HEX);
    send_text("ab", 1'b0);
    send_char(1'b0, NUL_CODE);
    send_text("0xAbC", 1'b1);
    send_char(1'b0, NUL_CODE);
    send_text("ff-", 1'b1);
    send_text("0xg", 1'b1);
    set_radix(BASE_INFER);
    send_text("0x1fZ", 1'b1);
    send_text("0Xg", 1'b1);
    send_text("017", 1'b1);
    send_char(1'b0, NUL_CODE);
    send_text("09", 1'b1);
    send_text("-0xFF", 1'b1);
    send_char(1'b0, NUL_CODE);
    send_text(" 42.", 1'b1);
    set_radix(6'd1);
    send_text("0001", 1'b1);
    set_radix(6'd36);
    send_text("zZ9", 1'b1);
    send_char(1'b0, NUL_CODE);
    set_radix(6'd63);
    send_text("Zz9_", 1'b1);
    set_radix(6'd2);
    send_text("101102", 1'b1);
    // A run of blanks moves the stop offset well past the sign.
    send_char(1'b1, CH_SPACE);
    repeat (20) send_char(1'b0, CH_SPACE);
    send_text("-11", 1'b0);
    send_char(1'b0, 8'd255);

    target = items_sent;
    for (int p = 0; p < 10; p++) begin
      set_radix((p < 9) ? phase_radix[p] : 6'($urandom_range(0, 63)));
      target += 75;
      while (items_sent < target) random_string((p < 9) ? phase_radix[p] : cfg_data);
    end

    drain();
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
